/* hdl/assert_macros.svh */
// Assertion helpers used by the timestamp sorter datapath RTL.
// Expects signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

/* hdl/tsrs_pkg.sv */
// Package for the timestamp record sorter: field widths, record type,
// controller states and the command/status structs. No dependencies.
package tsrs_pkg;

	localparam int MAX_RECORDS_DEF = 64;

	localparam int YEAR_W   = 14;
	localparam int TWO_W    = 7;
	localparam int STATUS_W = 4;
	localparam int CODE_W   = 10;

	// field order from MSB down makes a plain unsigned compare the sort key
	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [TWO_W-1:0]    month;
		logic [TWO_W-1:0]    day;
		logic [TWO_W-1:0]    hour;
		logic [TWO_W-1:0]    minute;
		logic [TWO_W-1:0]    second;
		logic [STATUS_W-1:0] status;
		logic [CODE_W-1:0]   code;
	} rec_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_mode;  // take requests into the store
		logic scan;       // issue one store read of the current pass
		logic emit;       // publish minimum, swap, advance pass
	} ctrl_cmd_t;

	typedef struct packed {
		logic load_last;  // accepted request closes the set
		logic scan_last;  // read being issued is the last of the pass
		logic pass_last;  // current pass is the final one
		logic out_free;   // output register can take a record
	} dp_status_t;

endpackage

/* hdl/tsrs_ifs.sv */
// Valid/ready channel interfaces for sorter input and output records.
// Depends on tsrs_pkg for field widths.
interface tsrs_in_if;
	logic                          valid;
	logic                          ready;
	logic [tsrs_pkg::YEAR_W-1:0]   year;
	logic [tsrs_pkg::TWO_W-1:0]    month;
	logic [tsrs_pkg::TWO_W-1:0]    day;
	logic [tsrs_pkg::TWO_W-1:0]    hour;
	logic [tsrs_pkg::TWO_W-1:0]    minute;
	logic [tsrs_pkg::TWO_W-1:0]    second;
	logic [tsrs_pkg::STATUS_W-1:0] status;
	logic [tsrs_pkg::CODE_W-1:0]   event_code;
	logic                          last_in;

	modport source (output valid, year, month, day, hour, minute, second, status,
		event_code, last_in, input ready);
	modport sink (input valid, year, month, day, hour, minute, second, status,
		event_code, last_in, output ready);
endinterface

interface tsrs_out_if;
	logic                          valid;
	logic                          ready;
	logic [tsrs_pkg::YEAR_W-1:0]   out_year;
	logic [tsrs_pkg::TWO_W-1:0]    out_month;
	logic [tsrs_pkg::TWO_W-1:0]    out_day;
	logic [tsrs_pkg::TWO_W-1:0]    out_hour;
	logic [tsrs_pkg::TWO_W-1:0]    out_minute;
	logic [tsrs_pkg::TWO_W-1:0]    out_second;
	logic [tsrs_pkg::STATUS_W-1:0] out_status;
	logic [tsrs_pkg::CODE_W-1:0]   out_code;
	logic                          last_out;

	modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
		out_second, out_status, out_code, last_out, input ready);
	modport sink (input valid, out_year, out_month, out_day, out_hour, out_minute,
		out_second, out_status, out_code, last_out, output ready);
endinterface

/* hdl/timestamp_record_selection_sort.sv */
// Timestamp record sorter. Records are taken one per cycle into a store of
// MAX_RECORDS entries; records beyond that are dropped. A record with last_in
// set closes the set: the block stops taking requests, sorts by selection
// sort and sends the records in ascending (year, month, ..., status, code)
// order, last_out on the final one. Pass i of n scans n-i entries through the
// single read port of the store, then compares the last read data and emits
// the minimum, waiting while the output register is still full. Loading
// resumes after the final record has been placed in the output register.
module timestamp_record_selection_sort #(
	parameter int MAX_RECORDS = tsrs_pkg::MAX_RECORDS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tsrs_in_if.sink     rec_in,
	tsrs_out_if.source  rec_out
);

	tsrs_pkg::ctrl_cmd_t  cmd;
	tsrs_pkg::dp_status_t status;

	tsrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	tsrs_datapath #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_in  (rec_in),
		.rec_out (rec_out),
		.cmd     (cmd),
		.status  (status)
	);

endmodule

/* hdl/tsrs_ctrl.sv */
// Sorter controller: load / scan / drain / emit state machine.
// Depends on tsrs_pkg; talks to tsrs_datapath through command and status.
module tsrs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tsrs_pkg::dp_status_t   status,
	output tsrs_pkg::ctrl_cmd_t    cmd
);

	tsrs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsrs_pkg::ST_LOAD: begin
				if (status.load_last) state_d = tsrs_pkg::ST_SCAN;
			end
			tsrs_pkg::ST_SCAN: begin
				if (status.scan_last) state_d = tsrs_pkg::ST_DRAIN;
			end
			// last read data gets compared here
			tsrs_pkg::ST_DRAIN: begin
				state_d = tsrs_pkg::ST_EMIT;
			end
			tsrs_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_d = status.pass_last ? tsrs_pkg::ST_LOAD : tsrs_pkg::ST_SCAN;
				end
			end
			default: state_d = tsrs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			tsrs_pkg::ST_LOAD:  cmd.load_mode = 1'b1;
			tsrs_pkg::ST_SCAN:  cmd.scan      = 1'b1;
			tsrs_pkg::ST_DRAIN: cmd           = '0;
			tsrs_pkg::ST_EMIT:  cmd.emit      = status.out_free;
			default:            cmd           = '0;
		endcase
	end

endmodule

/* hdl/tsrs_datapath.sv */
// Sorter datapath: record store memory, pass/scan counters, running minimum
// and output register. Depends on tsrs_pkg, tsrs_ifs and assert_macros.svh.
`include "assert_macros.svh"

module tsrs_datapath #(
	parameter int MAX_RECORDS = tsrs_pkg::MAX_RECORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tsrs_in_if.sink              rec_in,
	tsrs_out_if.source           rec_out,
	input  tsrs_pkg::ctrl_cmd_t  cmd,
	output tsrs_pkg::dp_status_t status
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int IDX_W = $clog2(MAX_RECORDS);

	logic [CNT_W-1:0] count_q, n_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic [CNT_W-1:0] j_ext, i_ext, n_m1;

	tsrs_pkg::rec_t   mem [MAX_RECORDS];
	tsrs_pkg::rec_t   rd_data_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_valid_s1, rd_first_s1;

	tsrs_pkg::rec_t   min_q, cur_q;
	logic [IDX_W-1:0] min_idx_q;

	tsrs_pkg::rec_t   out_rec_q;
	logic             out_last_q, out_valid_q;

	tsrs_pkg::rec_t   in_rec;
	logic             in_fire, room, we;
	logic [IDX_W-1:0] waddr;
	tsrs_pkg::rec_t   wdata;

	assign rec_in.ready = cmd.load_mode;
	assign in_fire      = rec_in.valid & cmd.load_mode;
	assign room         = count_q < CNT_W'(MAX_RECORDS);

	assign in_rec.year   = rec_in.year;
	assign in_rec.month  = rec_in.month;
	assign in_rec.day    = rec_in.day;
	assign in_rec.hour   = rec_in.hour;
	assign in_rec.minute = rec_in.minute;
	assign in_rec.second = rec_in.second;
	assign in_rec.status = rec_in.status;
	assign in_rec.code   = rec_in.event_code;

	assign j_ext = {1'b0, j_q};
	assign i_ext = {1'b0, i_q};
	assign n_m1  = n_q - CNT_W'(1);

	// swap only needs the old slot-i record written where the minimum was
	assign we    = (in_fire & room) | cmd.emit;
	assign waddr = cmd.emit ? min_idx_q : count_q[IDX_W-1:0];
	assign wdata = cmd.emit ? cur_q : in_rec;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.scan) rd_data_s1 <= mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rd_valid_s1 <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
			rd_first_s1 <= (j_q == i_q);
			rd_idx_s1   <= j_q;
			if (in_fire) begin
				if (rec_in.last_in) begin
					n_q     <= count_q + CNT_W'(room);
					count_q <= '0;
					i_q     <= '0;
					j_q     <= '0;
				end else if (room) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.scan) j_q <= j_q + IDX_W'(1);
			if (cmd.emit) begin
				i_q <= i_q + IDX_W'(1);
				j_q <= i_q + IDX_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rec_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// running minimum; strict less keeps the earlier index on ties
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (rd_first_s1 || (rd_data_s1 < min_q)) begin
				min_q     <= rd_data_s1;
				min_idx_q <= rd_idx_s1;
			end
			if (rd_first_s1) cur_q <= rd_data_s1;
		end
		if (cmd.emit) begin
			out_rec_q  <= min_q;
			out_last_q <= status.pass_last;
		end
	end

	assign status.load_last = in_fire & rec_in.last_in;
	assign status.scan_last = (j_ext == n_m1);
	assign status.pass_last = (i_ext == n_m1);
	assign status.out_free  = ~out_valid_q | rec_out.ready;

	assign rec_out.valid      = out_valid_q;
	assign rec_out.out_year   = out_rec_q.year;
	assign rec_out.out_month  = out_rec_q.month;
	assign rec_out.out_day    = out_rec_q.day;
	assign rec_out.out_hour   = out_rec_q.hour;
	assign rec_out.out_minute = out_rec_q.minute;
	assign rec_out.out_second = out_rec_q.second;
	assign rec_out.out_status = out_rec_q.status;
	assign rec_out.out_code   = out_rec_q.code;
	assign rec_out.last_out   = out_last_q;

	`ASSERT_CLK(a_count_range, count_q <= CNT_W'(MAX_RECORDS), "record count above store depth")
	`ASSERT_CLK(a_scan_in_range, cmd.scan |-> (j_ext < n_q), "scan read beyond stored set")
	`ASSERT_NEVER(a_emit_pending, cmd.emit && rd_valid_s1, "emit with compare still pending")

endmodule

/* tb/tb_timestamp_record_selection_sort.sv */
// Testbench for timestamp_record_selection_sort: drives record sets, predicts
// the sorted output in-line, and checks every emitted record field by field.
// Depends on tsrs_pkg, the tsrs_in_if/tsrs_out_if interfaces and the sorter RTL.
module tb_timestamp_record_selection_sort;

	localparam int DEPTH       = tsrs_pkg::MAX_RECORDS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_ROWS      = 16;
	localparam int PHASE_ITEMS = 40;

	localparam int YEAR_W   = tsrs_pkg::YEAR_W;
	localparam int TWO_W    = tsrs_pkg::TWO_W;
	localparam int STATUS_W = tsrs_pkg::STATUS_W;
	localparam int CODE_W   = tsrs_pkg::CODE_W;

	typedef struct packed {
		tsrs_pkg::rec_t rec;
		logic           last;
	} sorted_rec_t;

	typedef struct {
		tsrs_pkg::rec_t rec;
		bit             last;
		bit             typed;
		tsrs_pkg::rec_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tsrs_in_if  rec_in();
	tsrs_out_if rec_out();

	timestamp_record_selection_sort #(.MAX_RECORDS(DEPTH)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_in  (rec_in),
		.rec_out (rec_out)
	);

	always #2 clk = ~clk;

	tsrs_pkg::rec_t held_records[$];
	sorted_rec_t    expected_sorted[$];
	sorted_rec_t    head;
	stim_row_t      stim_rows[N_ROWS];
	int             src_idle_pct;
	int             snk_idle_pct;
	int             fail_count  = 0;
	int             cycle_count = 0;

	function automatic tsrs_pkg::rec_t rec_of(int y, int mo, int d, int h, int mi, int s,
		int st, int c);
		tsrs_pkg::rec_t r;
		r.year   = YEAR_W'(y);
		r.month  = TWO_W'(mo);
		r.day    = TWO_W'(d);
		r.hour   = TWO_W'(h);
		r.minute = TWO_W'(mi);
		r.second = TWO_W'(s);
		r.status = STATUS_W'(st);
		r.code   = CODE_W'(c);
		return r;
	endfunction

	function automatic int pick_value(int w, int hi);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return hi;
			2: return (1 << w) - 1;
			3: return int'($urandom & ((1 << w) - 1));
			4: return int'($urandom_range(0, 1));
			default: return int'($urandom_range(0, hi));
		endcase
	endfunction

	// keep the fields ahead of a random point, redraw the rest: builds
	// records that tie on a prefix and differ further down the key
	function automatic tsrs_pkg::rec_t vary_record(tsrs_pkg::rec_t base);
		tsrs_pkg::rec_t r;
		int             first_changed;
		r = base;
		first_changed = $urandom_range(0, 8);
		for (int f = first_changed; f < 8; f++) begin
			case (f)
				0: r.year   = YEAR_W'(pick_value(YEAR_W, 9999));
				1: r.month  = TWO_W'(pick_value(TWO_W, 99));
				2: r.day    = TWO_W'(pick_value(TWO_W, 99));
				3: r.hour   = TWO_W'(pick_value(TWO_W, 99));
				4: r.minute = TWO_W'(pick_value(TWO_W, 99));
				5: r.second = TWO_W'(pick_value(TWO_W, 99));
				6: r.status = STATUS_W'(pick_value(STATUS_W, 9));
				default: r.code = CODE_W'(pick_value(CODE_W, 999));
			endcase
		end
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	// one request; once accepted, update the held set and, on last, queue the
	// sorted records (or the typed-in result for rows that carry one)
	task automatic send_record(input tsrs_pkg::rec_t r, input bit last, input bit typed,
		input tsrs_pkg::rec_t want);
		tsrs_pkg::rec_t tmp;
		int             lo;
		int             n;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rec_in.valid <= 1'b0;
			@(posedge clk);
		end
		rec_in.valid      <= 1'b1;
		rec_in.year       <= r.year;
		rec_in.month      <= r.month;
		rec_in.day        <= r.day;
		rec_in.hour       <= r.hour;
		rec_in.minute     <= r.minute;
		rec_in.second     <= r.second;
		rec_in.status     <= r.status;
		rec_in.event_code <= r.code;
		rec_in.last_in    <= last;
		@(posedge clk);
		while (!rec_in.ready) @(posedge clk);

		// a full store drops the record, but its last flag still closes the set
		if (held_records.size() < DEPTH)
			held_records.push_back(r);
		if (last) begin
			n = held_records.size();
			for (int i = 0; i < n; i++) begin
				lo = i;
				for (int j = i + 1; j < n; j++)
					if (held_records[j] < held_records[lo])
						lo = j;
				tmp = held_records[i];
				held_records[i] = held_records[lo];
				held_records[lo] = tmp;
				if (!typed)
					expected_sorted.push_back('{held_records[i], i == n - 1});
			end
			if (typed)
				expected_sorted.push_back('{want, 1'b1});
			held_records.delete();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rec_out.valid && rec_out.ready) begin
			if (expected_sorted.size() == 0) begin
				$display("%0t: record out with none expected, got year %0d code %0d last %0d",
					$time, rec_out.out_year, rec_out.out_code, rec_out.last_out);
				fail_count++;
			end else begin
				head = expected_sorted.pop_front();
				check_field("year", 32'(head.rec.year), 32'(rec_out.out_year));
				check_field("month", 32'(head.rec.month), 32'(rec_out.out_month));
				check_field("day", 32'(head.rec.day), 32'(rec_out.out_day));
				check_field("hour", 32'(head.rec.hour), 32'(rec_out.out_hour));
				check_field("minute", 32'(head.rec.minute), 32'(rec_out.out_minute));
				check_field("second", 32'(head.rec.second), 32'(rec_out.out_second));
				check_field("status", 32'(head.rec.status), 32'(rec_out.out_status));
				check_field("code", 32'(head.rec.code), 32'(rec_out.out_code));
				check_field("last_out", 32'(head.last), 32'(rec_out.last_out));
			end
		end
		rec_out.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle_pct);
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("tb_timestamp_record_selection_sort: FAIL");
			$finish;
		end
	end

	initial begin
		tsrs_pkg::rec_t prev;
		tsrs_pkg::rec_t r;
		int             n;
		int             sent;
		bit             overflow_done;

		arst_n            = 1'b0;
		rec_in.valid      = 1'b0;
		rec_in.year       = '0;
		rec_in.month      = '0;
		rec_in.day        = '0;
		rec_in.hour       = '0;
		rec_in.minute     = '0;
		rec_in.second     = '0;
		rec_in.status     = '0;
		rec_in.event_code = '0;
		rec_in.last_in    = 1'b0;
		rec_out.ready     = 1'b0;
		src_idle_pct      = 36;
		snk_idle_pct      = 63;
		overflow_done     = 1'b0;

		// single-record sets come back unchanged with last_out set
		stim_rows[0]  = '{rec_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1,
			rec_of(0, 0, 0, 0, 0, 0, 0, 0)};
		stim_rows[1]  = '{rec_of(9999, 99, 99, 99, 99, 99, 9, 999), 1'b1, 1'b1,
			rec_of(9999, 99, 99, 99, 99, 99, 9, 999)};
		stim_rows[2]  = '{rec_of(16383, 127, 127, 127, 127, 127, 15, 1023), 1'b1, 1'b1,
			rec_of(16383, 127, 127, 127, 127, 127, 15, 1023)};
		// descending set, each record one step lower in one more significant field
		stim_rows[3]  = '{rec_of(2024, 6, 15, 12, 30, 45, 3, 500), 1'b0, 1'b0, '0};
		stim_rows[4]  = '{rec_of(2024, 6, 15, 12, 30, 45, 3, 499), 1'b0, 1'b0, '0};
		stim_rows[5]  = '{rec_of(2024, 6, 15, 12, 30, 45, 2, 500), 1'b0, 1'b0, '0};
		stim_rows[6]  = '{rec_of(2024, 6, 15, 12, 30, 44, 3, 500), 1'b0, 1'b0, '0};
		stim_rows[7]  = '{rec_of(2024, 6, 15, 12, 29, 45, 3, 500), 1'b0, 1'b0, '0};
		stim_rows[8]  = '{rec_of(2024, 6, 15, 11, 30, 45, 3, 500), 1'b0, 1'b0, '0};
		stim_rows[9]  = '{rec_of(2024, 6, 14, 12, 30, 45, 3, 500), 1'b0, 1'b0, '0};
		stim_rows[10] = '{rec_of(2024, 5, 15, 12, 30, 45, 3, 500), 1'b0, 1'b0, '0};
		stim_rows[11] = '{rec_of(2023, 6, 15, 12, 30, 45, 3, 500), 1'b1, 1'b0, '0};
		// equal keys
		stim_rows[12] = '{rec_of(1999, 12, 31, 23, 59, 59, 9, 0), 1'b0, 1'b0, '0};
		stim_rows[13] = '{rec_of(1999, 12, 31, 23, 59, 59, 9, 0), 1'b1, 1'b0, '0};
		// alternating bit patterns
		stim_rows[14] = '{rec_of(10922, 85, 42, 85, 42, 85, 10, 682), 1'b0, 1'b0, '0};
		stim_rows[15] = '{rec_of(5461, 42, 85, 42, 85, 42, 5, 341), 1'b1, 1'b0, '0};

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_record(stim_rows[i].rec, stim_rows[i].last, stim_rows[i].typed,
				stim_rows[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin src_idle_pct = 36; snk_idle_pct = 63; end
				1: begin src_idle_pct = 63; snk_idle_pct = 36; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (phase == 1 && !overflow_done) begin
					// overfill: the last two records are dropped, the final one closes the set
					n = DEPTH + 2;
					overflow_done = 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(16, 40);
				end else begin
					n = $urandom_range(1, 6);
				end
				prev = rec_of(0, 0, 0, 0, 0, 0, 0, 0);
				for (int k = 0; k < n; k++) begin
					r = (k == 0) ? vary_record(rec_of($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom)) : vary_record(prev);
					if (k == 0 && $urandom_range(0, 1))
						r = rec_of(pick_value(YEAR_W, 9999), pick_value(TWO_W, 99),
							pick_value(TWO_W, 99), pick_value(TWO_W, 99), pick_value(TWO_W, 99),
							pick_value(TWO_W, 99), pick_value(STATUS_W, 9),
							pick_value(CODE_W, 999));
					send_record(r, k == n - 1, 1'b0, r);
					prev = r;
					sent++;
				end
			end
		end

		rec_in.valid <= 1'b0;
		while (expected_sorted.size() != 0) @(posedge clk);
		repeat (2 * DEPTH) @(posedge clk);

		if (fail_count == 0)
			$display("tb_timestamp_record_selection_sort: PASS");
		else
			$display("tb_timestamp_record_selection_sort: FAIL");
		$finish;
	end

endmodule
